// ===== src/e2q_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// e2q_pkg
// shared types, constants and the arctangent table for the euler to
// quaternion unit
// ----------------------------------------------------------------------------
package e2q_pkg;

    localparam int ANGLE_WIDTH       = 16;
    localparam int QUAT_WIDTH        = 16;
    localparam int CORDIC_STAGES_DEF = 14;
    localparam int TRIG_WIDTH        = 32;
    localparam int HALF_SHIFT        = 32 - ANGLE_WIDTH;
    localparam int QUEUE_DEPTH       = 4;
    localparam int QPTR_WIDTH        = $clog2(QUEUE_DEPTH);

    localparam logic signed [33:0] HALF_PI_Q30   = 34'sd1686629713;
    localparam logic signed [33:0] PI_Q30        = 34'sd3373259426;
    localparam logic signed [31:0] INV_GAIN_Q30  = 32'sd652032874;

    typedef struct packed {
        logic signed [ANGLE_WIDTH-1:0] roll_angle;
        logic signed [ANGLE_WIDTH-1:0] pitch_angle;
        logic signed [ANGLE_WIDTH-1:0] yaw_angle;
    } angles_t;

    typedef struct packed {
        logic signed [QUAT_WIDTH-1:0] quat_w;
        logic signed [QUAT_WIDTH-1:0] quat_x;
        logic signed [QUAT_WIDTH-1:0] quat_y;
        logic signed [QUAT_WIDTH-1:0] quat_z;
    } quat_t;

    typedef struct packed {
        logic signed [TRIG_WIDTH-1:0] sr;
        logic signed [TRIG_WIDTH-1:0] cr;
        logic signed [TRIG_WIDTH-1:0] sp;
        logic signed [TRIG_WIDTH-1:0] cp;
        logic signed [TRIG_WIDTH-1:0] sy;
        logic signed [TRIG_WIDTH-1:0] cy;
    } trig_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic push;
        logic pop;
    } q_stat_t;

    function automatic logic signed [31:0] atan_q30(input int i);
        logic signed [31:0] a;
        case (i)
            0:  a = 32'sd843314856;
            1:  a = 32'sd497837829;
            2:  a = 32'sd263043836;
            3:  a = 32'sd133525158;
            4:  a = 32'sd67021686;
            5:  a = 32'sd33543515;
            6:  a = 32'sd16775850;
            7:  a = 32'sd8388437;
            8:  a = 32'sd4194282;
            9:  a = 32'sd2097149;
            10: a = 32'sd1048575;
            11: a = 32'sd524287;
            12: a = 32'sd262143;
            13: a = 32'sd131071;
            14: a = 32'sd65535;
            15: a = 32'sd32767;
            16: a = 32'sd16383;
            17: a = 32'sd8191;
            18: a = 32'sd4095;
            19: a = 32'sd2047;
            20: a = 32'sd1023;
            21: a = 32'sd511;
            22: a = 32'sd255;
            23: a = 32'sd127;
            24: a = 32'sd63;
            25: a = 32'sd31;
            26: a = 32'sd15;
            27: a = 32'sd7;
            28: a = 32'sd3;
            29: a = 32'sd1;
            default: a = 32'sd0;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

// ===== src/e2q_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// e2q_front
// half-angle fold and three-lane pipelined cordic, one stage per iteration
// ----------------------------------------------------------------------------
module e2q_front
    import e2q_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire angles_t s_data,
    input  wire logic    q_full,
    output logic         q_push,
    output trig_t        q_data
);

    localparam int N = CORDIC_STAGES;

    logic signed [31:0] x_reg [0:N][0:2];
    logic signed [31:0] y_reg [0:N][0:2];
    logic signed [31:0] z_reg [0:N][0:2];
    logic               flip_reg [0:N][0:2];
    logic [N:0]         v_reg;
    logic               en;
    logic signed [ANGLE_WIDTH-1:0] ang [0:2];
    logic signed [31:0] z_next [0:2];
    logic               flip_next [0:2];
    logic signed [31:0] c_out [0:2];
    logic signed [31:0] s_out [0:2];

    assign en      = !v_reg[N] || !q_full;
    assign s_ready = en;
    assign q_push  = en && v_reg[N];

    assign ang[0] = s_data.roll_angle;
    assign ang[1] = s_data.pitch_angle;
    assign ang[2] = s_data.yaw_angle;

    // fold the half angle into plus or minus half pi
    always_comb begin
        logic signed [33:0] h;
        for (int l = 0; l < 3; l++) begin
            h = 34'(signed'({ang[l], {HALF_SHIFT{1'b0}}}));
            if (h > HALF_PI_Q30) begin
                z_next[l]    = 32'(h - PI_Q30);
                flip_next[l] = 1'b1;
            end else if (h < -HALF_PI_Q30) begin
                z_next[l]    = 32'(h + PI_Q30);
                flip_next[l] = 1'b1;
            end else begin
                z_next[l]    = 32'(h);
                flip_next[l] = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[N-1:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                x_reg[0][l]    <= INV_GAIN_Q30;
                y_reg[0][l]    <= 32'sd0;
                z_reg[0][l]    <= z_next[l];
                flip_reg[0][l] <= flip_next[l];
            end
        end
    end

    for (genvar k = 1; k <= N; k++) begin : g_stage
        always_ff @(posedge aclk) begin
            if (en) begin
                for (int l = 0; l < 3; l++) begin
                    flip_reg[k][l] <= flip_reg[k-1][l];
                    if (!z_reg[k-1][l][31]) begin
                        x_reg[k][l] <= x_reg[k-1][l] - (y_reg[k-1][l] >>> (k-1));
                        y_reg[k][l] <= y_reg[k-1][l] + (x_reg[k-1][l] >>> (k-1));
                        z_reg[k][l] <= z_reg[k-1][l] - atan_q30(k-1);
                    end else begin
                        x_reg[k][l] <= x_reg[k-1][l] + (y_reg[k-1][l] >>> (k-1));
                        y_reg[k][l] <= y_reg[k-1][l] - (x_reg[k-1][l] >>> (k-1));
                        z_reg[k][l] <= z_reg[k-1][l] + atan_q30(k-1);
                    end
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            c_out[l] = flip_reg[N][l] ? -x_reg[N][l] : x_reg[N][l];
            s_out[l] = flip_reg[N][l] ? -y_reg[N][l] : y_reg[N][l];
        end
    end

    assign q_data.sr = s_out[0];
    assign q_data.cr = c_out[0];
    assign q_data.sp = s_out[1];
    assign q_data.cp = c_out[1];
    assign q_data.sy = s_out[2];
    assign q_data.cy = c_out[2];

endmodule
`default_nettype wire

// ===== src/e2q_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// e2q_queue
// short queue of sine and cosine sets between front and back
// ----------------------------------------------------------------------------
module e2q_queue
    import e2q_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  push,
    input  wire trig_t wr_data,
    input  wire logic  pop,
    output trig_t      rd_data,
    output q_stat_t    stat
);

    trig_t                 mem [0:QUEUE_DEPTH-1];
    logic [QPTR_WIDTH-1:0] wr_ptr_reg;
    logic [QPTR_WIDTH-1:0] rd_ptr_reg;
    logic [QPTR_WIDTH:0]   count_reg;
    logic                  do_push;
    logic                  do_pop;

    assign stat.full  = (count_reg == (QPTR_WIDTH+1)'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign stat.push  = push;
    assign stat.pop   = pop;
    assign rd_data    = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== src/e2q_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// e2q_back
// triple products, sums, rounding and saturation to q1.14
// ----------------------------------------------------------------------------
module e2q_back
    import e2q_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  q_empty,
    output logic       q_pop,
    input  wire trig_t q_data,
    output logic       m_valid,
    input  wire logic  m_ready,
    output quat_t      m_data
);

    localparam int SH = 62 - QUAT_WIDTH;

    logic               en;
    logic [3:0]         v_reg;
    logic signed [31:0] pcc_reg, pss_reg, psc_reg, pcs_reg, cy_reg, sy_reg;
    logic signed [63:0] wa_reg, wb_reg, xa_reg, xb_reg, ya_reg, yb_reg, za_reg, zb_reg;
    logic signed [64:0] sw_reg, sx_reg, sy_sum_reg, sz_reg;
    quat_t              out_reg;

    function automatic logic signed [QUAT_WIDTH-1:0] round_sat(input logic signed [64:0] s);
        logic signed [65:0] t;
        logic signed [65:0] r;
        logic signed [65:0] lim;
        lim = 66'sd1 <<< (QUAT_WIDTH-2);
        t   = 66'(s) + (66'sd1 <<< (SH-1));
        r   = t >>> SH;
        if (r > lim) begin
            r = lim;
        end else if (r < -lim) begin
            r = -lim;
        end
        return r[QUAT_WIDTH-1:0];
    endfunction

    function automatic logic signed [31:0] pair(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return 32'(p >>> 30);
    endfunction

    assign en      = !v_reg[3] || m_ready;
    assign q_pop   = en && !q_empty;
    assign m_valid = v_reg[3];
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[2:0], !q_empty};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pcc_reg <= pair(q_data.cr, q_data.cp);
            pss_reg <= pair(q_data.sr, q_data.sp);
            psc_reg <= pair(q_data.sr, q_data.cp);
            pcs_reg <= pair(q_data.cr, q_data.sp);
            cy_reg  <= q_data.cy;
            sy_reg  <= q_data.sy;

            wa_reg <= 64'(pcc_reg) * 64'(cy_reg);
            wb_reg <= 64'(pss_reg) * 64'(sy_reg);
            xa_reg <= 64'(psc_reg) * 64'(cy_reg);
            xb_reg <= 64'(pcs_reg) * 64'(sy_reg);
            ya_reg <= 64'(pcs_reg) * 64'(cy_reg);
            yb_reg <= 64'(psc_reg) * 64'(sy_reg);
            za_reg <= 64'(pcc_reg) * 64'(sy_reg);
            zb_reg <= 64'(pss_reg) * 64'(cy_reg);

            sw_reg     <= 65'(wa_reg) + 65'(wb_reg);
            sx_reg     <= 65'(xa_reg) - 65'(xb_reg);
            sy_sum_reg <= 65'(ya_reg) + 65'(yb_reg);
            sz_reg     <= 65'(za_reg) - 65'(zb_reg);

            out_reg.quat_w <= round_sat(sw_reg);
            out_reg.quat_x <= round_sat(sx_reg);
            out_reg.quat_y <= round_sat(sy_sum_reg);
            out_reg.quat_z <= round_sat(sz_reg);
        end
    end

endmodule
`default_nettype wire

// ===== src/euler_to_quaternion_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// euler_to_quaternion_unit
// roll, pitch and yaw to the z-y-x attitude quaternion
// throughput: one request per cycle while m_ready stays high, set by the
// one-stage-per-iteration cordic and the four-stage product pipeline
// reset: synchronous active-low aresetn empties pipelines and queue
// ----------------------------------------------------------------------------
module euler_to_quaternion_unit
    import e2q_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire angles_t s_data,
    output logic         m_valid,
    input  wire logic    m_ready,
    output quat_t        m_data
);

    logic    q_push;
    logic    q_pop;
    trig_t   q_wr_data;
    trig_t   q_rd_data;
    q_stat_t q_stat;

    e2q_front #(
        .CORDIC_STAGES(CORDIC_STAGES)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_stat.full),
        .q_push  (q_push),
        .q_data  (q_wr_data)
    );

    e2q_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_data (q_wr_data),
        .pop     (q_pop),
        .rd_data (q_rd_data),
        .stat    (q_stat)
    );

    e2q_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_stat.empty),
        .q_pop   (q_pop),
        .q_data  (q_rd_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_stat.push && q_stat.full))
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_stat.pop && q_stat.empty))
        else $error("pop from empty queue");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !q_stat.pop)
        else $error("queue popped while result stalled");

endmodule
`default_nettype wire

// ===== verif/euler_to_quaternion_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_to_quaternion_unit_tb
// drives roll, pitch and yaw requests through the unit with random gaps and
// output stalls, predicts each quaternion with a bit-exact cordic and product
// model, and compares every result in order against the predicted queue
// ----------------------------------------------------------------------------
module euler_to_quaternion_unit_tb;
    import e2q_pkg::*;

    localparam longint INV_GAIN = 64'sd652032874;
    localparam longint HALF_PI  = 64'sd1686629713;
    localparam longint PI_VAL   = 64'sd3373259426;
    localparam int     STAGES   = 14;
    localparam int     N_RANDOM = 1430;
    localparam longint LIMIT    = 400000;

    class quat_scoreboard;
        quat_t  pending[$];
        int     mismatches;

        function longint floor_sh(longint v, int s);
            return v >>> s;
        endfunction

        function void half_trig(logic signed [15:0] ang, output longint s,
                                output longint c);
            longint x, y, z, dx, dy;
            bit flip;
            x = INV_GAIN;
            y = 0;
            z = longint'(ang) * (64'sd1 << 16);
            flip = 0;
            if (z > HALF_PI) begin
                z -= PI_VAL;
                flip = 1;
            end else if (z < -HALF_PI) begin
                z += PI_VAL;
                flip = 1;
            end
            for (int i = 0; i < STAGES; i++) begin
                dx = floor_sh(y, i);
                dy = floor_sh(x, i);
                if (z >= 0) begin
                    x -= dx;
                    y += dy;
                    z -= longint'(atan_q30(i));
                end else begin
                    x += dx;
                    y -= dy;
                    z += longint'(atan_q30(i));
                end
            end
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        function longint prod3(longint a, longint b, longint c);
            return floor_sh(a * b, 30) * c;
        endfunction

        function logic signed [15:0] to_q14(longint v);
            longint r;
            r = floor_sh(v + (64'sd1 << 45), 46);
            if (r > 16384) r = 16384;
            if (r < -16384) r = -16384;
            return r[15:0];
        endfunction

        function void note_request(angles_t a);
            longint sr, cr, sp, cp, sy, cy;
            quat_t q;
            half_trig(a.roll_angle, sr, cr);
            half_trig(a.pitch_angle, sp, cp);
            half_trig(a.yaw_angle, sy, cy);
            q.quat_w = to_q14(prod3(cr, cp, cy) + prod3(sr, sp, sy));
            q.quat_x = to_q14(prod3(sr, cp, cy) - prod3(cr, sp, sy));
            q.quat_y = to_q14(prod3(cr, sp, cy) + prod3(sr, cp, sy));
            q.quat_z = to_q14(prod3(cr, cp, sy) - prod3(sr, sp, cy));
            pending.insert(pending.size(), q);
        endfunction

        function void check_result(quat_t got);
            quat_t want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
                return;
            end
            want = pending.pop_front();
            if (got.quat_w !== want.quat_w || got.quat_x !== want.quat_x ||
                got.quat_y !== want.quat_y || got.quat_z !== want.quat_z) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch exp w%0d x%0d y%0d z%0d got w%0d x%0d y%0d z%0d",
                             want.quat_w, want.quat_x, want.quat_y, want.quat_z,
                             got.quat_w, got.quat_x, got.quat_y, got.quat_z);
            end
        endfunction
    endclass

    logic    aclk = 0;
    logic    aresetn = 0;
    logic    s_valid = 0;
    logic    s_ready;
    angles_t s_data = '0;
    logic    m_valid;
    logic    m_ready = 0;
    quat_t   m_data;

    quat_scoreboard sb = new();
    longint cycles = 0;
    bit     sending_done = 0;
    bit     hold_off = 0;

    always #5 aclk = ~aclk;

    euler_to_quaternion_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    function int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function logic signed [15:0] rand_angle();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'($urandom);
        if (r == 1) return 16'sd25736 - 16'($urandom_range(0, 50));
        if (r == 2) return -16'sd25736 + 16'($urandom_range(0, 50));
        return 16'($urandom_range(0, 51472)) - 16'sd25736;
    endfunction

    task automatic send_request(angles_t a, bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            s_valid <= 0;
            repeat (g) @(posedge aclk);
        end
        s_valid <= 1;
        s_data  <= a;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(a);
    endtask

    task automatic send_triple(int r, int p, int y, bit gaps);
        angles_t a;
        a.roll_angle  = 16'(r);
        a.pitch_angle = 16'(p);
        a.yaw_angle   = 16'(y);
        send_request(a, gaps);
    endtask

    // result side: random stalls, one long hold-off on request
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
    end

    initial begin
        int g;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_off) begin
                m_ready <= 0;
                repeat (200) @(posedge aclk);
                hold_off = 0;
            end
            g = gap_len();
            if (g == 0) begin
                m_ready <= 1;
                @(posedge aclk);
            end else begin
                m_ready <= 0;
                repeat (g) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        angles_t a;
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        send_triple(0, 0, 0, 0);
        send_triple(25736, 0, 0, 0);
        send_triple(-25736, 0, 0, 0);
        send_triple(0, 25736, 0, 0);
        send_triple(0, -25736, 0, 0);
        send_triple(0, 0, 25736, 0);
        send_triple(0, 0, -25736, 0);
        send_triple(25736, 25736, 25736, 0);
        send_triple(-25736, -25736, -25736, 0);
        send_triple(32767, -32768, 32767, 0);
        send_triple(-32768, 32767, -32768, 0);
        send_triple(12868, 12868, 12868, 0);
        send_triple(-12868, 12868, -12868, 0);
        send_triple(12869, -12869, 30000, 0);
        send_triple(-1, 1, -1, 0);
        send_triple(16'h5555, 16'haaaa, 16'h5555, 0);
        send_triple(16'haaaa, 16'h5555, 16'haaaa, 0);
        send_triple(6434, -6434, 19302, 0);
        send_triple(28000, -30000, 0, 0);
        send_triple(100, 200, -300, 0);
        hold_off = 1;
        for (int i = 0; i < 40; i++) begin
            a.roll_angle  = rand_angle();
            a.pitch_angle = rand_angle();
            a.yaw_angle   = rand_angle();
            send_request(a, 0);
        end
        for (int i = 0; i < N_RANDOM; i++) begin
            a.roll_angle  = rand_angle();
            a.pitch_angle = rand_angle();
            a.yaw_angle   = rand_angle();
            send_request(a, $urandom_range(0, 3) != 0);
        end
        s_valid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (sb.mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
